>>> hw/rtl/balt_pkg.sv
// shared types and constants for the bus activity led timer
`timescale 1ns / 1ps

package balt_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int LED_W        = 4;
    localparam int TIMER_W      = 16;
    localparam int DIV_W        = 8;
    localparam int SHIFT_W      = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CH_CMP_W     = 5;

    localparam logic [TIMER_W-1:0] RED_BLINK_RST   = TIMER_W'(50);
    localparam logic [TIMER_W-1:0] GREEN_BLINK_RST = TIMER_W'(50);
    localparam logic [DIV_W-1:0]   REFRESH_RST     = DIV_W'(10);
    localparam logic [SHIFT_W-1:0] SHIFT_RST       = SHIFT_W'(3);

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_PACKET = 2'd1,
        REQ_RED    = 2'd2,
        REQ_GREEN  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_BLINK   = 8'd0,
        CFG_GREEN_BLINK = 8'd1,
        CFG_REFRESH     = 8'd2,
        CFG_SHIFT       = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] channel;
    } in_word_t;

    typedef struct packed {
        logic [LED_W-1:0] red_leds;
        logic [LED_W-1:0] green_leds;
    } out_word_t;

    typedef struct packed {
        logic [TIMER_W-1:0] red_blink_ticks;
        logic [TIMER_W-1:0] green_blink_ticks;
        logic [DIV_W-1:0]   refresh_period;
        logic [SHIFT_W-1:0] load_shift;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic packet;
        logic red_blink;
        logic green_blink;
        logic load;
    } chan_ctrl_t;

endpackage

>>> hw/rtl/balt_cfg_regs.sv
// configuration register bank
`timescale 1ns / 1ps

module balt_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [balt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [balt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output balt_pkg::cfg_t                   cfg
);

    balt_pkg::cfg_t cfg_reg;
    balt_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                balt_pkg::CFG_RED_BLINK: begin
                    cfg_next.red_blink_ticks = cfg_data[balt_pkg::TIMER_W-1:0];
                end
                balt_pkg::CFG_GREEN_BLINK: begin
                    cfg_next.green_blink_ticks = cfg_data[balt_pkg::TIMER_W-1:0];
                end
                balt_pkg::CFG_REFRESH: begin
                    cfg_next.refresh_period = cfg_data[balt_pkg::DIV_W-1:0];
                end
                balt_pkg::CFG_SHIFT: begin
                    cfg_next.load_shift = cfg_data[balt_pkg::SHIFT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_blink_ticks   <= balt_pkg::RED_BLINK_RST;
            cfg_reg.green_blink_ticks <= balt_pkg::GREEN_BLINK_RST;
            cfg_reg.refresh_period    <= balt_pkg::REFRESH_RST;
            cfg_reg.load_shift        <= balt_pkg::SHIFT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/balt_channel.sv
// per-channel red and green timers and packet counter
`timescale 1ns / 1ps

module balt_channel (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  balt_pkg::chan_ctrl_t            ctrl,
    input  balt_pkg::cfg_t                  cfg,
    output logic                            red_lit,
    output logic                            green_lit
);

    logic [balt_pkg::TIMER_W-1:0] red_timer_reg, red_timer_next;
    logic [balt_pkg::TIMER_W-1:0] green_timer_reg, green_timer_next;
    logic [balt_pkg::TIMER_W-1:0] pkt_count_reg, pkt_count_next;

    assign red_lit   = (red_timer_reg != '0);
    assign green_lit = (green_timer_reg != '0);

    always_comb begin
        red_timer_next   = red_timer_reg;
        green_timer_next = green_timer_reg;
        pkt_count_next   = pkt_count_reg;

        if (ctrl.red_blink) begin
            red_timer_next = cfg.red_blink_ticks;
        end else if (ctrl.tick && red_lit) begin
            red_timer_next = red_timer_reg - 1'b1;
        end

        if (ctrl.green_blink) begin
            green_timer_next = cfg.green_blink_ticks;
        end else if (ctrl.tick) begin
            if (ctrl.load && (pkt_count_reg != '0)) begin
                green_timer_next = pkt_count_reg >> cfg.load_shift;
            end else if (green_lit) begin
                green_timer_next = green_timer_reg - 1'b1;
            end
        end

        if (ctrl.packet) begin
            if (pkt_count_reg != '1) begin
                pkt_count_next = pkt_count_reg + 1'b1;
            end
        end else if (ctrl.tick && ctrl.load) begin
            pkt_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_timer_reg   <= '0;
            green_timer_reg <= '0;
            pkt_count_reg   <= '0;
        end else begin
            red_timer_reg   <= red_timer_next;
            green_timer_reg <= green_timer_next;
            pkt_count_reg   <= pkt_count_next;
        end
    end

endmodule

>>> hw/rtl/bus_activity_led_timer_core.sv
// top level of the bus activity led timer
`timescale 1ns / 1ps

// every input word is taken when offered and a new one can follow in the next cycle;
// each channel's timers and packet counter are registers, and a tick word
// yields one led word held in an output register, valid the cycle after the tick is
// taken; while that word waits for m_ready the input side is held off for every word

module bus_activity_led_timer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  balt_pkg::in_word_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output balt_pkg::out_word_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [balt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [balt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    balt_pkg::cfg_t cfg;

    logic                         in_fire;
    logic                         tick;
    logic                         load;
    logic [balt_pkg::DIV_W:0]     div_inc;
    logic [balt_pkg::DIV_W-1:0]   div_reg, div_next;
    logic                         out_valid_reg, out_valid_next;
    balt_pkg::out_word_t          out_data_reg, out_data_next;
    logic [balt_pkg::NUM_CHANNELS-1:0] red_lit, green_lit;

    balt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_ready = !out_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;
    assign tick    = in_fire && (s_data.req_type == balt_pkg::REQ_TICK);
    assign div_inc = {1'b0, div_reg} + 1'b1;
    assign load    = (div_inc >= {1'b0, cfg.refresh_period});

    genvar c;
    generate
        for (c = 0; c < balt_pkg::NUM_CHANNELS; c++) begin : g_chan
            localparam logic [balt_pkg::CH_CMP_W-1:0] CIDX = balt_pkg::CH_CMP_W'(c);
            logic                 hit;
            balt_pkg::chan_ctrl_t ctrl;

            assign hit = in_fire
                && ({{(balt_pkg::CH_CMP_W-2){1'b0}}, s_data.channel} == CIDX);

            assign ctrl.tick        = tick;
            assign ctrl.load        = load;
            assign ctrl.packet      = hit && (s_data.req_type == balt_pkg::REQ_PACKET);
            assign ctrl.red_blink   = hit && (s_data.req_type == balt_pkg::REQ_RED);
            assign ctrl.green_blink = hit && (s_data.req_type == balt_pkg::REQ_GREEN);

            balt_channel u_chan (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .cfg       (cfg),
                .red_lit   (red_lit[c]),
                .green_lit (green_lit[c])
            );
        end
    endgenerate

    always_comb begin
        out_data_next = out_data_reg;
        out_data_next.red_leds   = '0;
        out_data_next.green_leds = '0;
        for (int i = 0; i < balt_pkg::LED_W; i++) begin
            if (i < balt_pkg::NUM_CHANNELS) begin
                out_data_next.red_leds[i]   = red_lit[i];
                out_data_next.green_leds[i] = green_lit[i];
            end
        end
    end

    always_comb begin
        div_next       = div_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (tick) begin
            out_valid_next = 1'b1;
            // wrap the divider on a load tick
            div_next = load ? '0 : div_inc[balt_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            div_reg       <= div_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
